>>> rtl/core/psc_pkg.sv
// psc_pkg: constants and types shared by the periodic stream scheduler
// holds register map codes, field widths and the packed stream setup layout
// no dependencies
`timescale 1ns / 1ps

package psc_pkg;

	localparam int STREAM_COUNT = 7;
	localparam int SETUP_REGS   = 7;
	localparam int REG_COUNT    = SETUP_REGS + 1;
	localparam int REG_IDX_W    = $clog2(REG_COUNT);
	localparam int ADDR_W       = REG_IDX_W + 3;
	localparam int DATA_W       = 64;
	localparam int SETUP_W      = 56;
	localparam int COUNT_W      = 16;
	localparam int OFFSET_W     = 8;
	localparam int BYTE_W       = 8;
	localparam int STREAM_W     = 3;
	localparam int ACTIVE_W     = 3;

	localparam logic [REG_IDX_W-1:0] REG_ACTIVE      = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_SETUP_FIRST = REG_IDX_W'(1);

	typedef struct packed {
		logic [BYTE_W-1:0]   port;
		logic [BYTE_W-1:0]   command;
		logic [BYTE_W-1:0]   receiver;
		logic [OFFSET_W-1:0] high;
		logic [OFFSET_W-1:0] low;
		logic [COUNT_W-1:0]  period;
	} setup_t;

endpackage

>>> rtl/core/periodic_stream_scheduler_top.sv
// periodic_stream_scheduler_top: per-tick stream counters, priority pick and read request
// depends on psc_pkg for widths, register codes and the setup layout
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    tick
// out       output     out_valid / out_ready  stream_number, receiver_id, command_code,
//                                             read_offset, port_code
// cfg       input      apb, pready always 1   paddr, pwdata, prdata
//
// one request per cycle while the output is not stalled: the counter, compare and
// pick logic is combinational between the state registers and the output register
// a new request is taken while the output register is empty or being drained
// reset clears the counters, offsets and all configuration registers
// a stalled output holds its request and blocks only further input
`timescale 1ns / 1ps

module periodic_stream_scheduler_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           tick,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [psc_pkg::STREAM_W-1:0]   stream_number,
	output logic [psc_pkg::BYTE_W-1:0]     receiver_id,
	output logic [psc_pkg::BYTE_W-1:0]     command_code,
	output logic [psc_pkg::OFFSET_W-1:0]   read_offset,
	output logic [psc_pkg::BYTE_W-1:0]     port_code,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psc_pkg::ADDR_W-1:0]     paddr,
	input  logic [psc_pkg::DATA_W-1:0]     pwdata,
	output logic [psc_pkg::DATA_W-1:0]     prdata,
	output logic                           pready
);
	import psc_pkg::*;

	logic [ACTIVE_W-1:0]                        active_q;
	logic [SETUP_REGS-1:0][SETUP_W-1:0]         setup_q;
	logic [STREAM_COUNT-1:0][COUNT_W-1:0]       elapsed_q;
	logic [STREAM_COUNT-1:0][OFFSET_W-1:0]      offset_q;

	logic                                       out_valid_q;
	logic [STREAM_W-1:0]                        stream_number_q;
	logic [BYTE_W-1:0]                          receiver_id_q;
	logic [BYTE_W-1:0]                          command_code_q;
	logic [OFFSET_W-1:0]                        read_offset_q;
	logic [BYTE_W-1:0]                          port_code_q;

	logic                                       wr_en;
	logic [REG_IDX_W-1:0]                       reg_idx;
	logic [REG_IDX_W-1:0]                       setup_idx;

	logic [ACTIVE_W-1:0]                        n_eff;
	logic [STREAM_COUNT-1:0]                    active_vec;
	logic [STREAM_COUNT-1:0]                    hit_vec;
	logic [STREAM_COUNT-1:0]                    fire_vec;
	logic [STREAM_COUNT-1:0][COUNT_W-1:0]       inc_cnt;
	logic [STREAM_COUNT-1:0][COUNT_W-1:0]       elapsed_d;
	logic [STREAM_COUNT-1:0][OFFSET_W-1:0]      offset_d;
	setup_t                                     sel_setup;
	setup_t                                     cur_setup;
	logic [OFFSET_W-1:0]                        sel_offset;
	logic [OFFSET_W-1:0]                        off_inc;
	logic [OFFSET_W-1:0]                        off_next;
	logic [STREAM_W-1:0]                        pick_idx;
	logic                                       fire;
	logic                                       accept;
	logic                                       go;

	// configuration port
	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;
	assign reg_idx   = paddr[ADDR_W-1:3];
	assign setup_idx = reg_idx - REG_SETUP_FIRST;

	always_comb begin
		if (reg_idx == REG_ACTIVE) begin
			prdata = DATA_W'(active_q);
		end else begin
			prdata = DATA_W'(setup_q[setup_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			setup_q  <= '0;
		end else if (wr_en) begin
			if (reg_idx == REG_ACTIVE) begin
				active_q <= pwdata[ACTIVE_W-1:0];
			end else begin
				setup_q[setup_idx] <= pwdata[SETUP_W-1:0];
			end
		end
	end

	// tick evaluation
	assign n_eff = (active_q > ACTIVE_W'(STREAM_COUNT)) ? ACTIVE_W'(STREAM_COUNT) : active_q;

	always_comb begin
		for (int k = 0; k < STREAM_COUNT; k++) begin
			cur_setup     = setup_t'(setup_q[k]);
			active_vec[k] = ACTIVE_W'(k) < n_eff;
			if (active_vec[k] && (elapsed_q[k] != '1)) begin
				inc_cnt[k] = elapsed_q[k] + COUNT_W'(1);
			end else begin
				inc_cnt[k] = elapsed_q[k];
			end
			hit_vec[k] = active_vec[k] && (inc_cnt[k] >= cur_setup.period);
		end
	end

	// lowest set bit wins
	assign fire_vec = hit_vec & (~hit_vec + STREAM_COUNT'(1));
	assign fire     = |hit_vec;

	always_comb begin
		pick_idx   = '0;
		sel_setup  = '0;
		sel_offset = '0;
		for (int k = 0; k < STREAM_COUNT; k++) begin
			if (fire_vec[k]) begin
				pick_idx   = pick_idx | STREAM_W'(k);
				sel_setup  = sel_setup | setup_t'(setup_q[k]);
				sel_offset = sel_offset | offset_q[k];
			end
		end
	end

	assign off_inc  = sel_offset + OFFSET_W'(1);
	assign off_next = (off_inc > sel_setup.high) ? sel_setup.low : off_inc;

	always_comb begin
		for (int k = 0; k < STREAM_COUNT; k++) begin
			if (fire_vec[k]) begin
				elapsed_d[k] = inc_cnt[k] - sel_setup.period;
				offset_d[k]  = off_next;
			end else begin
				elapsed_d[k] = inc_cnt[k];
				offset_d[k]  = offset_q[k];
			end
		end
	end

	// request handshake
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign go       = accept && tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			offset_q  <= '0;
		end else if (go) begin
			elapsed_q <= elapsed_d;
			offset_q  <= offset_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= tick && fire;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && fire) begin
			stream_number_q <= pick_idx;
			receiver_id_q   <= sel_setup.receiver;
			command_code_q  <= sel_setup.command;
			read_offset_q   <= off_next;
			port_code_q     <= sel_setup.port;
		end
	end

	assign out_valid     = out_valid_q;
	assign stream_number = stream_number_q;
	assign receiver_id   = receiver_id_q;
	assign command_code  = command_code_q;
	assign read_offset   = read_offset_q;
	assign port_code     = port_code_q;

`ifndef SYNTH
	a_single_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fire_vec))
		else $error("more than one stream picked in a tick");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !tick) |=> ($stable(elapsed_q) && $stable(offset_q) && !out_valid_q))
		else $error("idle tick changed state or made a request");

	a_no_fire_no_request: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !fire) |=> !out_valid_q)
		else $error("request without a firing stream");

	a_stream_active: assert property (@(posedge clk) disable iff (!arst_n)
		(go && fire) |=> (out_valid_q && (ACTIVE_W'(stream_number_q) < $past(n_eff))))
		else $error("request from an inactive stream");

	a_offset_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(go && fire) |=> (offset_q[stream_number_q] == read_offset_q))
		else $error("stored offset differs from requested offset");
`endif

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for the periodic stream scheduler
// depends on psc_pkg and periodic_stream_scheduler_top; keeps its own schedule model
// directed table first, then a starvation run and random phases under varied pacing
`timescale 1ns / 1ps

module tb_top;

	import psc_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_STREAM0 = REG_SETUP_FIRST;
	localparam logic [REG_IDX_W-1:0] REG_STREAM1 = REG_SETUP_FIRST + 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STREAM2 = REG_SETUP_FIRST + 3'd2;
	localparam int PHASES       = 13;
	localparam int PHASE_TICKS  = 36;
	localparam int STARVE_TICKS = 30;

	typedef struct packed {
		logic [STREAM_W-1:0] stream;
		logic [BYTE_W-1:0]   receiver;
		logic [BYTE_W-1:0]   command;
		logic [OFFSET_W-1:0] offset;
		logic [BYTE_W-1:0]   port;
	} fire_req_t;

	typedef enum logic [1:0] {ROW_WRITE, ROW_TICK} row_kind_e;
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} row_exp_e;
	typedef enum logic [1:0] {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_e;

	typedef struct {
		row_kind_e              kind;
		logic [REG_IDX_W-1:0]   idx;
		logic [DATA_W-1:0]      data;
		logic                   t;
		row_exp_e               how;
		fire_req_t              req;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, tick;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STREAM_W-1:0] stream_number;
	logic [BYTE_W-1:0] receiver_id, command_code, port_code;
	logic [OFFSET_W-1:0] read_offset;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// schedule model state
	logic [ACTIVE_W-1:0] sch_active;
	setup_t              sch_setup[SETUP_REGS];
	logic [COUNT_W-1:0]  sch_elapsed[STREAM_COUNT];
	logic [OFFSET_W-1:0] sch_offset[STREAM_COUNT];

	fire_req_t due_requests[$];
	stim_row_t dir_rows[$];

	int mismatches = 0;
	int requests_checked = 0;
	int ticks_sent = 0;
	int cfg_writes = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	always #1 clk = ~clk;

	periodic_stream_scheduler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tick(tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stream_number(stream_number),
		.receiver_id(receiver_id),
		.command_code(command_code),
		.read_offset(read_offset),
		.port_code(port_code),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// one scheduler tick: bump active counters, lowest ready stream fires
	task automatic advance_schedule(input logic t, output bit fired, output fire_req_t req);
		int n;
		setup_t s;
		logic [OFFSET_W-1:0] nxt;
		fired = 1'b0;
		req = '0;
		if (t !== 1'b1)
			return;
		n = (sch_active > STREAM_COUNT) ? STREAM_COUNT : sch_active;
		for (int k = 0; k < n; k++)
			if (sch_elapsed[k] != '1)
				sch_elapsed[k] = sch_elapsed[k] + 1'b1;
		for (int k = 0; k < n && !fired; k++) begin
			s = sch_setup[k];
			if (sch_elapsed[k] >= s.period) begin
				nxt = sch_offset[k] + 8'd1;
				if (nxt > s.high)
					nxt = s.low;
				sch_offset[k] = nxt;
				sch_elapsed[k] = sch_elapsed[k] - s.period;
				req = '{STREAM_W'(k), s.receiver, s.command, nxt, s.port};
				fired = 1'b1;
			end
		end
	endtask

	// write a register, then read it back in the next transfer
	task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] kept;
		if (idx == REG_ACTIVE)
			kept = value & ((64'd1 << ACTIVE_W) - 1);
		else
			kept = value & ((64'd1 << SETUP_W) - 1);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == REG_ACTIVE)
			sch_active = value[ACTIVE_W-1:0];
		else
			sch_setup[idx - REG_SETUP_FIRST] = value[SETUP_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== kept)
			flag_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, kept));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	task automatic send_tick(input logic t, input row_exp_e how, input fire_req_t given);
		bit fired;
		fire_req_t req;
		in_valid <= 1'b1;
		tick <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_schedule(t, fired, req);
		case (how)
			EXP_NONE: ;
			EXP_GIVEN: due_requests.push_back(given);
			default: if (fired) due_requests.push_back(req);
		endcase
		ticks_sent++;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// drop valid, wait for every due request, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_requests.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_pace(input pace_e mode);
		case (mode)
			PACE_SEND_IDLE: begin
				send_gap_pct = 81;
				recv_stall_pct = 0;
			end
			PACE_RECV_STALL: begin
				send_gap_pct = 0;
				recv_stall_pct = 81;
			end
			PACE_BOTH: begin
				send_gap_pct = 14;
				recv_stall_pct = 14;
			end
			default: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	function automatic logic [DATA_W-1:0] random_setup();
		setup_t s;
		case ($urandom_range(9))
			0: s.period = '0;
			1: s.period = '1;
			2: s.period = COUNT_W'($urandom_range(65535));
			default: s.period = COUNT_W'($urandom_range(1, 6));
		endcase
		s.low = OFFSET_W'($urandom_range(255));
		// mostly narrow windows so the wrap back to the low bound comes often
		s.high = ($urandom_range(3) == 0) ? OFFSET_W'($urandom_range(255)) :
			s.low + OFFSET_W'($urandom_range(7));
		s.receiver = BYTE_W'($urandom_range(255));
		s.command = BYTE_W'($urandom_range(255));
		s.port = BYTE_W'($urandom_range(255));
		return DATA_W'(s);
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		fire_req_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_requests.size() == 0) begin
				flag_mismatch($sformatf("request from stream %0d with none due", stream_number));
			end else begin
				want = due_requests.pop_front();
				requests_checked++;
				if (stream_number !== want.stream)
					flag_mismatch($sformatf("stream_number %0d, expected %0d",
						stream_number, want.stream));
				if (receiver_id !== want.receiver)
					flag_mismatch($sformatf("receiver_id %h, expected %h",
						receiver_id, want.receiver));
				if (command_code !== want.command)
					flag_mismatch($sformatf("command_code %h, expected %h",
						command_code, want.command));
				if (read_offset !== want.offset)
					flag_mismatch($sformatf("read_offset %h, expected %h",
						read_offset, want.offset));
				if (port_code !== want.port)
					flag_mismatch($sformatf("port_code %h, expected %h", port_code, want.port));
			end
		end
	end

	initial begin
		logic [DATA_W-1:0] v;
		logic t;
		int sent;
		arst_n = 1'b0;
		in_valid = 1'b0;
		tick = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sch_active = '0;
		for (int k = 0; k < SETUP_REGS; k++)
			sch_setup[k] = '0;
		for (int k = 0; k < STREAM_COUNT; k++) begin
			sch_elapsed[k] = '0;
			sch_offset[k] = '0;
		end

		// no streams enabled yet, then every stream on with all-zero settings
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_NONE, '0});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b0, EXP_NONE, '0});
		dir_rows.push_back('{ROW_WRITE, REG_ACTIVE, 64'd7, 1'b0, EXP_MODEL, '0});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_GIVEN, '0});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b0, EXP_NONE, '0});
		// stream 0 all ones not ready within these ticks, stream 1 zero period with low above high
		dir_rows.push_back('{ROW_WRITE, REG_STREAM0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
			EXP_MODEL, '0});
		dir_rows.push_back('{ROW_WRITE, REG_STREAM1, 64'h007F_8001_00FF_0000, 1'b0,
			EXP_MODEL, '0});
		dir_rows.push_back('{ROW_WRITE, REG_ACTIVE, 64'd2, 1'b0, EXP_MODEL, '0});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_GIVEN,
			'{3'd1, 8'h01, 8'h80, 8'hFF, 8'h7F}});
		// offset 255 rolls over to zero, which is not above the high bound
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_GIVEN,
			'{3'd1, 8'h01, 8'h80, 8'h00, 8'h7F}});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_GIVEN,
			'{3'd1, 8'h01, 8'h80, 8'hFF, 8'h7F}});
		dir_rows.push_back('{ROW_WRITE, REG_STREAM2, 64'h000F_55AA_0605_0003, 1'b0,
			EXP_MODEL, '0});
		dir_rows.push_back('{ROW_WRITE, REG_STREAM1, 64'h0055_4433_2010_0002, 1'b0,
			EXP_MODEL, '0});
		dir_rows.push_back('{ROW_WRITE, REG_ACTIVE, 64'd3, 1'b0, EXP_MODEL, '0});
		for (int k = 0; k < 8; k++)
			dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, (k != 4), EXP_MODEL, '0});
		dir_rows.push_back('{ROW_WRITE, REG_ACTIVE, 64'd0, 1'b0, EXP_MODEL, '0});
		dir_rows.push_back('{ROW_TICK, REG_ACTIVE, 64'd0, 1'b1, EXP_NONE, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_pace(PACE_FULL);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				program_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_tick(dir_rows[i].t, dir_rows[i].how, dir_rows[i].req);
			end
		end

		// stream 0 fires every tick and keeps stream 1 waiting well past its period
		settle();
		program_reg(REG_STREAM0, 64'd0);
		program_reg(REG_STREAM1, 64'h0056_3412_FF00_0010);
		program_reg(REG_ACTIVE, 64'd2);
		repeat (STARVE_TICKS) send_tick(1'b1, EXP_MODEL, '0);
		settle();
		program_reg(REG_STREAM0, 64'h0000_0000_0000_FFFF);
		repeat (6) send_tick(1'b1, EXP_MODEL, '0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			set_pace(pace_e'(p % 4));
			for (int k = 0; k < SETUP_REGS; k++) begin
				case (p)
					1: v = '1;
					2: v = '0;
					default: v = random_setup();
				endcase
				program_reg(REG_SETUP_FIRST + REG_IDX_W'(k), v);
			end
			if (p <= 2)
				v = 64'd7;
			else if (p == 3)
				v = 64'd0;
			else
				v = DATA_W'($urandom_range(1, 7));
			program_reg(REG_ACTIVE, v);
			sent = 0;
			while (sent < PHASE_TICKS) begin
				t = ($urandom_range(99) < 85);
				send_tick(t, EXP_MODEL, '0);
				if (t)
					sent++;
			end
		end

		settle();
		repeat (8) @(posedge clk);
		$display("run covered %0d ticks and %0d register writes, %0d requests checked",
			ticks_sent, cfg_writes, requests_checked);
		$display("including a starvation run and %0d random phases", PHASES);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d requests still due", due_requests.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
